// ===== rtl/dedup_set_table_core_assert.svh =====
// assertion macros shared by the set table rtl
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef DEDUP_SET_TABLE_CORE_ASSERT_SVH
`define DEDUP_SET_TABLE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define DST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dst assertion failed");
// next-cycle implication
`define DST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dst assertion failed");
`else
`define DST_ASSERT_NOW(label, clk, rst, ante, cons)
`define DST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/dst_pkg.sv =====
// types, constants and codes of the dedup set table
// no dependencies; used by dst_cell and dedup_set_table_core
package dst_pkg;

  localparam int CAPACITY    = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int KEY_FIELD_W = 32;
  localparam int COUNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;

  localparam int IN_BITS   = OP_W + KEY_FIELD_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 1 + KEY_FIELD_W + COUNT_W + STATUS_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_POP      = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_EXEC
  } state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic valid;    // cell holds a live key
    logic compare;  // capture match against the broadcast key
    logic shift;    // take the key of the upper neighbor
    logic load;     // take the broadcast key (append)
  } cell_ctrl_t;

endpackage

// ===== rtl/dedup_set_table_core.sv =====
// top level of the dedup set table: sequencer, cell chain and result register
// depends on dst_pkg, dst_cell and dedup_set_table_core_assert.svh
//
// Holds up to CAPACITY distinct keys in insertion order in a row of cells;
// cell 0 is the oldest key. Each transaction passes through a compare
// cycle in which every cell checks its key against the broadcast key and
// registers a match bit, and an update cycle that appends the key to the
// first free cell, or shifts every cell at and above the hit (or all of
// them for pop) down by one from its upper neighbor. The next transaction
// is accepted in the update cycle when the result register is free; a
// result that is not taken holds the update cycle. No clearing pass after
// reset: cell contents are only read below the fill count.
`include "dedup_set_table_core_assert.svh"
module dedup_set_table_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // opcode [1:0], key [33:2], zero padding above
  input  logic [dst_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // found [0], popped_key [32:1], count [39:33], status [41:40], zero padding
  output logic [dst_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import dst_pkg::*;

  // sequencer
  state_t state, state_next;
  logic   in_accept;
  logic   out_free;
  logic   compare_en;
  logic   exec_done;

  // held transaction
  op_t                op;
  logic [KEY_WIDTH-1:0] key;

  // fill count
  logic [COUNT_W-1:0] count, count_next;

  // cell chain
  cell_ctrl_t           ctrl_vec [CAPACITY];
  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]  match_vec;
  logic [CAPACITY-1:0]  valid_vec;
  logic [CAPACITY-1:0]  shift_vec;
  logic [CAPACITY-1:0]  load_vec;
  logic [CAPACITY-1:0]  above_hit;

  // update decisions
  logic    hit;
  logic    is_full;
  logic    is_empty;
  logic    do_append;
  logic    do_remove;
  logic    do_pop;
  logic    res_found;
  status_t res_status;
  logic [KEY_FIELD_W-1:0] res_popped;

  // result register
  logic                   out_valid;
  logic                   out_found;
  logic [KEY_FIELD_W-1:0] out_popped;
  logic [COUNT_W-1:0]     out_count;
  status_t                out_status;

  assign out_free  = !out_valid || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_COMPARE;
      end
      ST_COMPARE: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = in_accept ? ST_COMPARE : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    compare_en    = 1'b0;
    exec_done     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_COMPARE: begin
        compare_en = 1'b1;
      end
      ST_EXEC: begin
        s_axis_tready = out_free;
        exec_done     = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the transaction; only low KEY_WIDTH bits of the key are kept
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op  <= op_t'(s_axis_tdata[OP_W-1:0]);
      key <= KEY_WIDTH'(s_axis_tdata[OP_W +: KEY_FIELD_W]);
    end
  end

  // keys are distinct, so at most one cell matches
  assign hit      = |match_vec;
  assign is_full  = (count == COUNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  assign do_append = exec_done && (op == OP_INSERT) && !hit && !is_full;
  assign do_remove = exec_done && (op == OP_REMOVE) && hit;
  assign do_pop    = exec_done && (op == OP_POP) && !is_empty;

  // cells at and above the single hit position
  assign above_hit = ~(match_vec - CAPACITY'(1));

  always_comb begin
    shift_vec = '0;
    if (do_pop) begin
      shift_vec = '1;
    end else if (do_remove) begin
      shift_vec = above_hit;
    end
  end

  // result fields
  always_comb begin
    res_found  = 1'b0;
    res_status = STATUS_OK;
    res_popped = '0;
    count_next = count;
    unique case (op)
      OP_INSERT: begin
        res_found = hit;
        if (!hit && is_full) begin
          res_status = STATUS_FULL;
        end else if (!hit) begin
          count_next = count + COUNT_W'(1);
        end
      end
      OP_REMOVE: begin
        res_found = hit;
        if (hit) count_next = count - COUNT_W'(1);
      end
      OP_CONTAINS: begin
        res_found = hit;
      end
      OP_POP: begin
        if (is_empty) begin
          res_status = STATUS_EMPTY;
        end else begin
          res_found  = 1'b1;
          res_popped = KEY_FIELD_W'(cell_key[0]);
          count_next = count - COUNT_W'(1);
        end
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec_done) begin
      count <= count_next;
    end
  end

  // cell row; each cell takes its upper neighbor's key on a shift
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      assign valid_vec[i] = (COUNT_W'(i) < count);
      assign load_vec[i]  = do_append && (count[IDX_W-1:0] == IDX_W'(i));

      assign ctrl_vec[i].valid   = valid_vec[i];
      assign ctrl_vec[i].compare = compare_en;
      assign ctrl_vec[i].shift   = shift_vec[i];
      assign ctrl_vec[i].load    = load_vec[i];

      if (i == CAPACITY - 1) begin : g_top
        dst_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl_vec[i]),
          .cmp_key  (key),
          .next_key ({KEY_WIDTH{1'b0}}),
          .key      (cell_key[i]),
          .match    (match_vec[i])
        );
      end else begin : g_mid
        dst_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl_vec[i]),
          .cmp_key  (key),
          .next_key (cell_key[i+1]),
          .key      (cell_key[i]),
          .match    (match_vec[i])
        );
      end
    end
  endgenerate

  // result register parts the two sides
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_done) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_found  <= res_found;
      out_popped <= res_popped;
      out_count  <= count_next;
      out_status <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'({out_status, out_count, out_popped, out_found});

  // checks
  `DST_ASSERT_NOW(a_single_match, clk, rst, state == ST_EXEC, $onehot0(match_vec))
  `DST_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= COUNT_W'(CAPACITY))
  `DST_ASSERT_NEXT(a_compare_then_exec, clk, rst, state == ST_COMPARE, state == ST_EXEC)
  `DST_ASSERT_NEXT(a_full_keeps_count, clk, rst,
    exec_done && (res_status == STATUS_FULL), $stable(count))

endmodule

// ===== rtl/dst_cell.sv =====
// one storage cell of the set table: key register, comparator, shift mux
// depends on dst_pkg
module dst_cell (
  input  logic                          clk,
  input  dst_pkg::cell_ctrl_t           ctrl,
  input  logic [dst_pkg::KEY_WIDTH-1:0] cmp_key,
  input  logic [dst_pkg::KEY_WIDTH-1:0] next_key,
  output logic [dst_pkg::KEY_WIDTH-1:0] key,
  output logic                          match
);
  import dst_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key <= next_key;
    end else if (ctrl.load) begin
      key <= cmp_key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      match <= ctrl.valid && (key == cmp_key);
    end
  end

endmodule

// ===== verif/dedup_set_table_core_test.sv =====
// self-checking testbench of dedup_set_table_core: directed rows, then random insert/drain phases
// depends on dst_pkg and the set table rtl; the expected results come from a queue-based predictor or typed rows
module dedup_set_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dst_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int STEADY_ITEMS = 150;   // tail of the run with no idling
  localparam int PHASE_LEN = 120;
  localparam logic [31:0] KEY_MASK = 32'hFFFF_FFFF >> (32 - KEY_WIDTH);

  typedef struct packed {
    logic                found;
    logic [31:0]         popped_key;
    logic [COUNT_W-1:0]  count;
    status_t             status;
  } set_result_t;

  typedef struct {
    op_t         op;
    logic [31:0] key;
    bit          typed;   // result written out by hand
    set_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [31:0] held_keys[$];        // predicted table contents, oldest first
  set_result_t pending_results[$];  // results still owed by the block
  int mismatches = 0;
  int cycle_count = 0;
  bit steady = 1'b0;

  dedup_set_table_core dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime,
               pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // applies one operation to the predicted table and returns its result
  function automatic set_result_t apply_set_op(op_t op, logic [31:0] key);
    set_result_t r;
    logic [31:0] k;
    int hit;
    r = '0;
    k = key & KEY_MASK;
    hit = -1;
    foreach (held_keys[i]) begin
      if (hit < 0 && held_keys[i] == k) hit = i;
    end
    case (op)
      OP_INSERT: begin
        if (hit >= 0) r.found = 1'b1;
        else if (held_keys.size() >= CAPACITY) r.status = STATUS_FULL;
        else held_keys.push_back(k);
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          held_keys.delete(hit);
        end
      end
      OP_CONTAINS: r.found = (hit >= 0);
      default: begin
        if (held_keys.size() == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.found = 1'b1;
          r.popped_key = held_keys.pop_front();
        end
      end
    endcase
    r.count = COUNT_W'(held_keys.size());
    return r;
  endfunction

  // mostly a held key when hit_pct says so, else a small or a full-range value
  function automatic logic [31:0] pick_key(int hit_pct);
    if (held_keys.size() != 0 && $urandom_range(99) < hit_pct)
      return held_keys[$urandom_range(held_keys.size() - 1)];
    if ($urandom_range(3) == 0) return 32'($urandom_range(15));
    return $urandom;
  endfunction

  // one transaction on the input stream; valid stays up between back-to-back items
  task automatic send_op(op_t op, logic [31:0] key, bit typed, set_result_t want);
    set_result_t predicted;
    if (!steady && $urandom_range(4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_DATA_W'({key, op});
    do @(posedge clk); while (!s_axis_tready);
    predicted = apply_set_op(op, key);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // output back-pressure: random stall bursts until the steady tail
  initial begin
    @(negedge rst);
    forever begin
      if (steady || $urandom_range(2) != 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // result checker: found [0], popped_key [32:1], count, status above
  always @(posedge clk) begin
    set_result_t want;
    set_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.found = m_axis_tdata[0];
      got.popped_key = m_axis_tdata[32:1];
      got.count = m_axis_tdata[33 +: COUNT_W];
      got.status = status_t'(m_axis_tdata[33 + COUNT_W +: STATUS_W]);
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $realtime, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found) begin
          $display("%0t: found expected %b actual %b", $realtime, want.found, got.found);
          mismatches++;
        end
        if (got.popped_key !== want.popped_key) begin
          $display("%0t: popped_key expected %h actual %h", $realtime,
                   want.popped_key, got.popped_key);
          mismatches++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $realtime, want.count, got.count);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   want.status, got.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t directed_rows[20];
    op_t op;
    bit filling;
    int pick;
    directed_rows = '{
      // empty table: pop flags empty, lookups miss
      '{OP_POP,      32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0, STATUS_EMPTY}},
      '{OP_CONTAINS, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0, STATUS_OK}},
      '{OP_REMOVE,   32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 7'd0, STATUS_OK}},
      // key extremes, duplicate insert leaves the table alone
      '{OP_INSERT,   32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd1, STATUS_OK}},
      '{OP_INSERT,   32'h0000_0000, 1'b1, '{1'b1, 32'h0, 7'd1, STATUS_OK}},
      '{OP_INSERT,   32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 7'd2, STATUS_OK}},
      '{OP_CONTAINS, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 7'd2, STATUS_OK}},
      '{OP_INSERT,   32'h8000_0000, 1'b1, '{1'b0, 32'h0, 7'd3, STATUS_OK}},
      '{OP_INSERT,   32'h0000_0001, 1'b1, '{1'b0, 32'h0, 7'd4, STATUS_OK}},
      // remove from the middle closes the gap
      '{OP_REMOVE,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 7'd3, STATUS_OK}},
      '{OP_CONTAINS, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 7'd3, STATUS_OK}},
      // pop ignores its key
      '{OP_POP,      32'hAAAA_AAAA, 1'b1, '{1'b1, 32'h0, 7'd2, STATUS_OK}},
      '{OP_POP,      32'h5555_5555, 1'b1, '{1'b1, 32'h8000_0000, 7'd1, STATUS_OK}},
      '{OP_REMOVE,   32'h0000_0001, 1'b1, '{1'b1, 32'h0, 7'd0, STATUS_OK}},
      '{OP_POP,      32'h0000_0001, 1'b1, '{1'b0, 32'h0, 7'd0, STATUS_EMPTY}},
      '{OP_INSERT,   32'h1234_5678, 1'b0, '0},
      '{OP_INSERT,   32'hFEDC_BA98, 1'b0, '0},
      '{OP_REMOVE,   32'h1234_5678, 1'b0, '0},
      '{OP_CONTAINS, 32'hFEDC_BA98, 1'b0, '0},
      '{OP_POP,      32'h0F0F_0F0F, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
              directed_rows[i].want);

    // alternate fill-heavy and drain-heavy phases so the table swings
    // between full (dropped inserts) and empty (pops on empty)
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      filling = ((n / PHASE_LEN) % 2) == 0;
      if (n == RANDOM_ITEMS - STEADY_ITEMS) steady = 1'b1;
      pick = $urandom_range(99);
      if (filling)
        op = pick < 70 ? OP_INSERT : pick < 82 ? OP_CONTAINS : pick < 94 ? OP_REMOVE : OP_POP;
      else
        op = pick < 10 ? OP_INSERT : pick < 20 ? OP_CONTAINS : pick < 50 ? OP_REMOVE : OP_POP;
      send_op(op, pick_key(op == OP_INSERT ? 25 : 70), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
